// ===== rtl/txr_pkg.sv =====
// ============================================================================
// txr_pkg - shared types and constants for the transmit ring
// Character codes, operation and result kind codes, and the command and
// result records that pass between the front and back parts.
// ============================================================================
package txr_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int DEF_BUFFER_DEPTH = 256;
    localparam int DEF_BURST_LIMIT  = 16;

    // Field widths
    localparam int CHAR_W     = 8;
    localparam int KIND_W     = 2;
    localparam int FILL_W     = 9;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_PAD_W  = OUT_DATA_W - (CHAR_W + 1 + 1 + FILL_W);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

    // Input operation codes
    localparam logic OP_PUT   = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SENT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IDLE = 2'd2;

    // Classified input item
    typedef struct packed {
        logic              op;
        logic [CHAR_W-1:0] ch;
        logic              is_lf;
    } t_cmd;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] tx_byte;
        logic              accepted;
        logic              last;
        logic              irq;
        logic [FILL_W-1:0] fill;
    } t_result;

endpackage

// ===== rtl/txr_front.sv =====
// ============================================================================
// txr_front - input side of the transmit ring
// Takes input transfers, marks line feeds on puts, and holds them in a
// two-entry command queue that the back part drains at its own pace.
// ============================================================================
module txr_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [txr_pkg::CHAR_W-1:0]  i_s_axis_tdata,   // char_in
    input  logic                        i_s_axis_tuser,   // op
    output txr_pkg::t_cmd               o_cmd,
    output logic                        o_cmd_valid,
    input  logic                        i_cmd_pop
);
    import txr_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_used, n_used;
    logic              w_push;
    t_cmd              w_cmd;

    // Classify the incoming item
    always_comb begin
        w_cmd.op    = i_s_axis_tuser;
        w_cmd.ch    = i_s_axis_tdata;
        w_cmd.is_lf = (i_s_axis_tuser == OP_PUT) && (i_s_axis_tdata == CH_LF);
    end

    assign o_s_axis_tready = (r_used != QCNT_W'(QUEUE_DEPTH));
    assign w_push          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cmd_valid     = (r_used != '0);
    assign o_cmd           = r_q[r_rd_ptr];

    // Pointer and occupancy update; depth is a power of two so pointers wrap
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_used   = r_used;
        if (w_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_cmd_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        case ({w_push, i_cmd_pop})
            2'b10:   n_used = r_used + 1'b1;
            2'b01:   n_used = r_used - 1'b1;
            default: n_used = r_used;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_used   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_used   <= n_used;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// ===== rtl/txr_back.sv =====
// ============================================================================
// txr_back - ring storage and command execution
// Executes queued puts and transmitter-empty events against the byte ring,
// and drives results through a one-entry output register.
// ============================================================================
module txr_back #(
    parameter int BUFFER_DEPTH = txr_pkg::DEF_BUFFER_DEPTH,
    parameter int BURST_LIMIT  = txr_pkg::DEF_BURST_LIMIT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  txr_pkg::t_cmd                   i_cmd,
    input  logic                            i_cmd_valid,
    output logic                            o_cmd_pop,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tx_byte[7:0], accepted[8], tx_irq_enable[9], fill_level[18:10], zeros
    output logic [txr_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    output logic [txr_pkg::KIND_W-1:0]      o_m_axis_tuser,   // kind
    output logic                            o_m_axis_tlast
);
    import txr_pkg::*;

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int BL_W  = $clog2(BURST_LIMIT + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_LF    = 3'b010,
        ST_BURST = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [BL_W-1:0]   r_left, n_left;
    logic              r_irq, n_irq;
    logic              r_out_valid;
    t_result           r_out;
    t_result           w_res;
    logic              w_load;
    logic              w_out_free;
    logic              w_reject;
    logic              w_we;
    logic [CHAR_W-1:0] w_wdata;
    logic [CHAR_W-1:0] r_ring [BUFFER_DEPTH];
    logic [CHAR_W-1:0] r_rd_data;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // A line feed needs two free entries, any other character one
    assign w_reject = i_cmd.is_lf ? (r_count > CNT_W'(BUFFER_DEPTH - 2))
                                  : (r_count == CNT_W'(BUFFER_DEPTH));

    // Command sequencer
    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_count   = r_count;
        n_left    = r_left;
        n_irq     = r_irq;
        o_cmd_pop = 1'b0;
        w_we      = 1'b0;
        w_wdata   = i_cmd.ch;
        w_load    = 1'b0;
        w_res     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == OP_PUT) begin
                        if (w_reject) begin
                            w_load = 1'b1;
                            w_res.kind = KIND_ACK;
                            w_res.last = 1'b1;
                        end else if (i_cmd.is_lf) begin
                            // carriage return first, line feed from ST_LF
                            w_we    = 1'b1;
                            w_wdata = CH_CR;
                            n_wp    = ptr_inc(r_wp);
                            n_count = r_count + 1'b1;
                            n_state = ST_LF;
                        end else begin
                            w_we    = 1'b1;
                            n_wp    = ptr_inc(r_wp);
                            n_count = r_count + 1'b1;
                            n_irq   = 1'b1;
                            w_load  = 1'b1;
                            w_res.kind     = KIND_ACK;
                            w_res.accepted = 1'b1;
                            w_res.last     = 1'b1;
                        end
                    end else if (r_count == '0) begin
                        // nothing to send: drop the interrupt
                        n_irq  = 1'b0;
                        w_load = 1'b1;
                        w_res.kind = KIND_IDLE;
                        w_res.last = 1'b1;
                    end else begin
                        if (32'(r_count) > 32'(BURST_LIMIT)) begin
                            n_left = BL_W'(BURST_LIMIT);
                        end else begin
                            n_left = BL_W'(r_count);
                        end
                        n_state = ST_BURST;
                    end
                end
            end
            ST_LF: begin
                if (w_out_free) begin
                    w_we    = 1'b1;
                    w_wdata = CH_LF;
                    n_wp    = ptr_inc(r_wp);
                    n_count = r_count + 1'b1;
                    n_irq   = 1'b1;
                    w_load  = 1'b1;
                    w_res.kind     = KIND_ACK;
                    w_res.accepted = 1'b1;
                    w_res.last     = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_BURST: begin
                if (w_out_free) begin
                    n_rp    = ptr_inc(r_rp);
                    n_count = r_count - 1'b1;
                    n_left  = r_left - 1'b1;
                    w_load  = 1'b1;
                    w_res.kind    = KIND_SENT;
                    w_res.tx_byte = r_rd_data;
                    w_res.last    = (r_left == BL_W'(1));
                    if (r_left == BL_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // flag and fill level as they stand after this result
        w_res.irq  = n_irq;
        w_res.fill = FILL_W'(n_count);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_count     <= '0;
            r_left      <= '0;
            r_irq       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
            r_left  <= n_left;
            r_irq   <= n_irq;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    // Ring memory; read port follows the next read pointer so the head byte
    // is registered and ready in the following cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_ring[r_wp] <= w_wdata;
        end
        r_rd_data <= r_ring[n_rp];
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.fill, r_out.irq,
                              r_out.accepted, r_out.tx_byte};

endmodule

// ===== rtl/tx_ring_crlf_burst_drain.sv =====
// A put result is loaded into the output register when the back part pops the put;
// a line feed first writes CR, then gives its result from ST_LF. A drain event enters
// ST_BURST, which sends bytes one per cycle while the output register is free. Puts
// are taken one per cycle under the same condition; a line feed also takes ST_LF.
// Reset (i_rst_n low, synchronous) empties the queue and ring pointers and clears the
// interrupt flag; ring contents are not cleared and need no clearing pass.
// ============================================================================
// tx_ring_crlf_burst_drain - serial transmit ring with CR/LF expansion
// Front part queues classified items; back part stores bytes, drains bursts
// on transmitter-empty events and reports each step as a result transfer.
// ============================================================================
module tx_ring_crlf_burst_drain #(
    parameter int BUFFER_DEPTH = txr_pkg::DEF_BUFFER_DEPTH,
    parameter int BURST_LIMIT  = txr_pkg::DEF_BURST_LIMIT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [txr_pkg::CHAR_W-1:0]      i_s_axis_tdata,   // char_in
    input  logic                            i_s_axis_tuser,   // op
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tx_byte[7:0], accepted[8], tx_irq_enable[9], fill_level[18:10], zeros
    output logic [txr_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    output logic [txr_pkg::KIND_W-1:0]      o_m_axis_tuser,   // kind
    output logic                            o_m_axis_tlast
);
    import txr_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_pop;

    txr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_cmd           (w_cmd),
        .o_cmd_valid     (w_cmd_valid),
        .i_cmd_pop       (w_cmd_pop)
    );

    txr_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .BURST_LIMIT  (BURST_LIMIT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cmd_valid     (w_cmd_valid),
        .o_cmd_pop       (w_cmd_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
